>>> sv/grouped_one_shot_timer_table_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grouped one-shot timer table
// Clocked, reset-qualified property wrappers.
// ---------------------------------------------------------------------------
`ifndef GROUPED_ONE_SHOT_TIMER_TABLE_DEFINES_SVH
`define GROUPED_ONE_SHOT_TIMER_TABLE_DEFINES_SVH

// implication checked every cycle outside reset
`define GOTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define GOTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/gott_pkg.sv
// ---------------------------------------------------------------------------
// gott_pkg
// Shared constants and codes of the grouped one-shot timer table.
// ---------------------------------------------------------------------------
package gott_pkg;

  localparam int unsigned MaxTimersDef = 64;
  localparam int unsigned NumGroupsDef = 1024;
  localparam int unsigned GroupW       = 11;
  localparam logic [10:0] AlwaysLive   = 11'd1024;
  localparam logic [15:0] TickReset    = 16'd50;

  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpAdd   = 3'd1;
  localparam logic [2:0] OpDel   = 3'd2;
  localparam logic [2:0] OpAlloc = 3'd3;
  localparam logic [2:0] OpFree  = 3'd4;

  localparam logic [2:0] KindFired = 3'd0;
  localparam logic [2:0] KindAdd   = 3'd1;
  localparam logic [2:0] KindDel   = 3'd2;
  localparam logic [2:0] KindAlloc = 3'd3;
  localparam logic [2:0] KindFree  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StNoAlloc = 2'd2;
  localparam logic [1:0] StNoMem   = 2'd3;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [31:0] tag;
    logic [10:0] grp;
    logic        found;
    logic        last;
  } res_t;

endpackage

>>> sv/gott_group_map.sv
// ---------------------------------------------------------------------------
// gott_group_map
// Group liveness memory with a rotating free-group search that reads and then checks one id at a time.
// ---------------------------------------------------------------------------
module gott_group_map
  import gott_pkg::*;
#(
  parameter int unsigned NumGroups = NumGroupsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // liveness lookup of one group, answer next cycle
  input  logic [10:0] look_grp_i,
  output logic        look_live_o,
  // free a group
  input  logic        free_i,
  input  logic [10:0] free_grp_i,
  // allocation search
  input  logic        alloc_start_i,
  output logic        alloc_done_o,
  output logic        alloc_ok_o,
  output logic [10:0] alloc_grp_o,
  output logic        clr_busy_o
);

  localparam int unsigned GW = $clog2(NumGroups);

  logic            mem_q [NumGroups];
  logic [GW:0]     clr_q;
  logic            clr_busy;
  logic [GW-1:0]   cursor_q, cursor_d;
  logic [GW-1:0]   probe_q, probe_d;
  logic [GW:0]     cnt_q, cnt_d;
  logic            srch_q, srch_d, chk_q, chk_d;
  logic            rd_q;
  logic            wr_en;
  logic [GW-1:0]   wr_addr;
  logic            wr_val;
  logic [GW-1:0]   rd_addr;
  logic            look_sel_q, look_inr_q;
  logic [GW-1:0]   chk_addr_q;
  logic            done_d, ok_d;

  assign clr_busy   = !clr_q[GW];
  assign clr_busy_o = clr_busy;

  // lookup address is the probe while searching
  assign rd_addr = srch_q ? probe_q : look_grp_i[GW-1:0];

  // write mux: clearing pass, allocation mark, free
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_grp_i[GW-1:0];
    wr_val  = 1'b0;
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[GW-1:0];
    end else if (done_d && ok_d) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr_q;
      wr_val  = 1'b1;
    end else if (free_i) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_val;
    end
    rd_q <= mem_q[rd_addr];
  end

  // search: probe read, check next
  always_comb begin
    srch_d   = srch_q;
    chk_d    = 1'b0;
    probe_d  = probe_q;
    cnt_d    = cnt_q;
    cursor_d = cursor_q;
    done_d   = 1'b0;
    ok_d     = 1'b0;
    if (alloc_start_i) begin
      srch_d  = 1'b1;
      probe_d = cursor_q;
      cnt_d   = '0;
    end else if (srch_q) begin
      chk_d   = 1'b1;
      srch_d  = 1'b0;
    end else if (chk_q) begin
      if (chk_addr_q != '0 && !rd_q) begin
        done_d   = 1'b1;
        ok_d     = 1'b1;
        cursor_d = chk_addr_q;
      end else if (cnt_q == (GW+1)'(NumGroups - 1)) begin
        done_d = 1'b1;
      end else begin
        srch_d  = 1'b1;
        probe_d = (probe_q == GW'(NumGroups - 1)) ? '0 : probe_q + 1'b1;
        cnt_d   = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      cursor_q <= '0;
      probe_q  <= '0;
      cnt_q    <= '0;
      srch_q   <= 1'b0;
      chk_q    <= 1'b0;
    end else begin
      if (clr_busy) clr_q <= clr_q + 1'b1;
      cursor_q <= cursor_d;
      probe_q  <= probe_d;
      cnt_q    <= cnt_d;
      srch_q   <= srch_d;
      chk_q    <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= rd_addr;
    look_sel_q <= (look_grp_i == AlwaysLive);
    look_inr_q <= (look_grp_i != '0) && (look_grp_i < 11'(NumGroups));
  end

  assign look_live_o  = look_sel_q || (look_inr_q && rd_q);
  assign alloc_done_o = done_d;
  assign alloc_ok_o   = ok_d;
  assign alloc_grp_o  = ok_d ? 11'(chk_addr_q) : '0;

endmodule

>>> sv/gott_timer_store.sv
// ---------------------------------------------------------------------------
// gott_timer_store
// Timer entry memories with registered reads and one write port each.
// ---------------------------------------------------------------------------
module gott_timer_store
  import gott_pkg::*;
#(
  parameter int unsigned MaxTimers = MaxTimersDef
) (
  input  logic                         clk_i,
  input  logic [$clog2(MaxTimers)-1:0] rd_idx_i,
  output logic [31:0]                  rd_time_o,
  output logic [31:0]                  rd_tag_o,
  output logic [10:0]                  rd_grp_o,
  output logic [$clog2(MaxTimers):0]   rd_link_o,
  input  logic                         wr_time_i,
  input  logic                         wr_ent_i,
  input  logic [$clog2(MaxTimers)-1:0] wr_idx_i,
  input  logic [31:0]                  wr_time_val_i,
  input  logic [31:0]                  wr_tag_i,
  input  logic [10:0]                  wr_grp_i,
  input  logic                         wr_link_i,
  input  logic [$clog2(MaxTimers)-1:0] wr_link_idx_i,
  input  logic [$clog2(MaxTimers):0]   wr_link_val_i
);

  localparam int unsigned IW = $clog2(MaxTimers);

  logic [31:0] time_q [MaxTimers];
  logic [31:0] tag_q  [MaxTimers];
  logic [10:0] grp_q  [MaxTimers];
  logic [IW:0] link_q [MaxTimers];

  // entry fields
  always_ff @(posedge clk_i) begin
    if (wr_time_i) time_q[wr_idx_i] <= wr_time_val_i;
    if (wr_ent_i) begin
      tag_q[wr_idx_i] <= wr_tag_i;
      grp_q[wr_idx_i] <= wr_grp_i;
    end
    if (wr_link_i) link_q[wr_link_idx_i] <= wr_link_val_i;
    rd_time_o <= time_q[rd_idx_i];
    rd_tag_o  <= tag_q[rd_idx_i];
    rd_grp_o  <= grp_q[rd_idx_i];
    rd_link_o <= link_q[rd_idx_i];
  end

endmodule

>>> sv/grouped_one_shot_timer_table.sv
// ---------------------------------------------------------------------------
// grouped_one_shot_timer_table
// Insertion-ordered one-shot timer list with group liveness.
// ---------------------------------------------------------------------------
// Input channel (valid/stall) takes op, group_id, period, timer_tag; output
// channel (valid/stall) gives kind, status, fired_tag, result_group, found,
// last. tick_amount is written by cfg_we_i/cfg_wdata_i.
// One item is worked at a time; input stall is high while busy.
// A tick walks the list, reading each entry and then comparing and writing
// it back, with a group lookup for each expired timer. Fired results leave
// one entry behind.
// Delete walks to the first match, reading and comparing each entry visited.
// Add does a group lookup, a slot search of one slot a cycle, then links.
// Allocation probes one group at a time, each probe read and then checked.
// Free checks its group and then sends its status.
// Each result waits in an output register; while the receiver stalls the
// walk pauses with it, nothing is lost.
// After reset a clearing pass sweeps the group liveness memory, one group a
// cycle, during which no item is taken.
// ---------------------------------------------------------------------------
module grouped_one_shot_timer_table
  import gott_pkg::*;
#(
  parameter int unsigned MAX_TIMERS = MaxTimersDef,
  parameter int unsigned NUM_GROUPS = NumGroupsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [10:0] group_id_i,
  input  logic [31:0] period_i,
  input  logic [31:0] timer_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] fired_tag_o,
  output logic [10:0] result_group_o,
  output logic        found_o,
  output logic        last_o
);

`include "grouped_one_shot_timer_table_defines.svh"

  localparam int unsigned IW = $clog2(MAX_TIMERS);
  localparam logic [IW:0] NoneIdx = (IW+1)'(MAX_TIMERS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_LIVE  = 4'd3;
  localparam logic [3:0] S_OUT   = 4'd4;
  localparam logic [3:0] S_SLOT  = 4'd5;
  localparam logic [3:0] S_AGRP  = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [15:0] tick_q;
  logic [2:0]  op_q;
  logic [10:0] grp_q;
  logic [31:0] period_q, tag_q;
  logic [MAX_TIMERS-1:0] used_q, used_d;
  logic [IW:0] head_q, head_d, tail_q, tail_d;
  logic [IW:0] cur_q, cur_d, prev_q, prev_d;
  logic [IW:0] slot_q, slot_d;
  logic        pend_q, pend_d;
  logic        out_v_q, out_v_d;
  res_t        out_q, out_d, hold_q, hold_d;

  // store ports
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_time, rd_tag;
  logic [10:0]   rd_grp;
  logic [IW:0]   rd_link;
  logic          wr_time, wr_ent, wr_link;
  logic [IW-1:0] wr_idx, wr_link_idx;
  logic [31:0]   wr_time_val;
  logic [IW:0]   wr_link_val;

  // group map ports
  logic [10:0] look_grp;
  logic        look_live, free_en, alloc_start, alloc_done, alloc_ok, clr_busy;
  logic [10:0] alloc_grp;
  logic        grp_valid;
  logic        out_free;

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || clr_busy;

  gott_timer_store #(.MaxTimers(MAX_TIMERS)) u_store (
    .clk_i, .rd_idx_i(rd_idx), .rd_time_o(rd_time), .rd_tag_o(rd_tag),
    .rd_grp_o(rd_grp), .rd_link_o(rd_link), .wr_time_i(wr_time),
    .wr_ent_i(wr_ent), .wr_idx_i(wr_idx), .wr_time_val_i(wr_time_val),
    .wr_tag_i(tag_q), .wr_grp_i(grp_q), .wr_link_i(wr_link),
    .wr_link_idx_i(wr_link_idx), .wr_link_val_i(wr_link_val)
  );

  gott_group_map #(.NumGroups(NUM_GROUPS)) u_groups (
    .clk_i, .rst_ni, .look_grp_i(look_grp), .look_live_o(look_live),
    .free_i(free_en), .free_grp_i(grp_q), .alloc_start_i(alloc_start),
    .alloc_done_o(alloc_done), .alloc_ok_o(alloc_ok), .alloc_grp_o(alloc_grp),
    .clr_busy_o(clr_busy)
  );

  assign grp_valid = (grp_q == AlwaysLive) || (grp_q != '0 && grp_q < 11'(NUM_GROUPS));
  assign rd_idx    = cur_q[IW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
    cur_d = cur_q; prev_d = prev_q; slot_d = slot_q; pend_d = pend_q;
    out_v_d = out_v_q && out_stall_i; out_d = out_q; hold_d = hold_q;
    wr_time = 1'b0; wr_ent = 1'b0; wr_link = 1'b0;
    wr_idx = cur_q[IW-1:0]; wr_time_val = rd_time - 32'(tick_q);
    wr_link_idx = prev_q[IW-1:0]; wr_link_val = rd_link;
    look_grp = grp_q; free_en = 1'b0; alloc_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cur_d = head_q; prev_d = NoneIdx; slot_d = '0; pend_d = 1'b0;
        if (in_valid_i && !in_stall_o) begin
          unique case (op_i)
            OpTick, OpDel: state_d = S_RD;
            OpAdd:   state_d = S_AGRP;
            OpAlloc: state_d = S_ALLOC;
            OpFree:  state_d = S_AGRP;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (cur_q >= NoneIdx) state_d = S_FLUSH;
        else state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_RD;
        cur_d   = rd_link;
        if (op_q == OpDel) begin
          if (rd_tag == tag_q) begin
            wr_link = (prev_q != NoneIdx);
            if (prev_q == NoneIdx) head_d = rd_link;
            if (tail_q == cur_q) tail_d = prev_q;
            used_d[cur_q[IW-1:0]] = 1'b0;
            hold_d = '{kind: KindDel, status: StOk, tag: '0, grp: '0,
                       found: 1'b1, last: 1'b1};
            pend_d = 1'b1;
            state_d = S_OUT;
          end else begin
            prev_d = cur_q;
          end
        end else if (rd_time < 32'(tick_q)) begin
          if (pend_q && !out_free) begin
            // an earlier fired result still waits; hold this entry
            state_d = S_EVAL;
            cur_d   = cur_q;
          end else begin
            wr_link = (prev_q != NoneIdx);
            if (prev_q == NoneIdx) head_d = rd_link;
            if (tail_q == cur_q) tail_d = prev_q;
            used_d[cur_q[IW-1:0]] = 1'b0;
            look_grp = rd_grp;
            state_d  = S_LIVE;
          end
        end else begin
          wr_time = 1'b1;
          prev_d  = cur_q;
        end
      end
      S_LIVE: begin
        // liveness of the removed timer is known now; if its group is live, the
        // earlier fired result goes out and this one is held until the next is known
        state_d = S_RD;
        if (look_live) begin
          if (pend_q) begin
            out_v_d = 1'b1; out_d = hold_q;
          end
          hold_d = '{kind: KindFired, status: StOk, tag: rd_tag, grp: rd_grp,
                     found: 1'b0, last: 1'b0};
          pend_d = 1'b1;
        end
      end
      S_OUT: begin
        // hand a result to the output register
        if (out_free) begin
          if (pend_q && hold_q.last) begin
            out_v_d = 1'b1; out_d = hold_q; pend_d = 1'b0; state_d = S_IDLE;
          end else if (hold_q.last) begin
            state_d = S_IDLE;
          end else if (pend_q) begin
            out_v_d = 1'b1; out_d = hold_q; pend_d = 1'b0;
          end else begin
            pend_d = 1'b1; state_d = S_RD;
          end
        end
      end
      S_FLUSH: begin
        // end of walk: mark the last fired result or send the delete ack
        if (op_q == OpDel) begin
          hold_d = '{kind: KindDel, status: StOk, tag: '0, grp: '0,
                     found: 1'b0, last: 1'b1};
          pend_d = 1'b1; state_d = S_OUT;
        end else if (pend_q) begin
          hold_d.last = 1'b1; state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_AGRP: begin
        // group lookup is back; add or free
        hold_d = '{kind: (op_q == OpAdd) ? KindAdd : KindFree, status: StOk,
                   tag: '0, grp: '0, found: 1'b0, last: 1'b1};
        if (op_q == OpFree) begin
          if (grp_q == '0 || grp_q == AlwaysLive || grp_q >= 11'(NUM_GROUPS))
            hold_d.status = StInvalid;
          else free_en = 1'b1;
          pend_d = 1'b1; state_d = S_OUT;
        end else if (!grp_valid) begin
          hold_d.status = StInvalid; pend_d = 1'b1; state_d = S_OUT;
        end else if (!look_live) begin
          hold_d.status = StNoAlloc; pend_d = 1'b1; state_d = S_OUT;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        // lowest free slot, one per cycle
        if (slot_q >= NoneIdx) begin
          hold_d.status = StNoMem; pend_d = 1'b1; state_d = S_OUT;
        end else if (!used_q[slot_q[IW-1:0]]) begin
          wr_idx = slot_q[IW-1:0]; wr_time = 1'b1; wr_ent = 1'b1;
          wr_time_val = period_q;
          wr_link = 1'b1; wr_link_idx = slot_q[IW-1:0]; wr_link_val = NoneIdx;
          used_d[slot_q[IW-1:0]] = 1'b1;
          if (head_q >= NoneIdx) head_d = slot_q;
          tail_d = slot_q;
          if (head_q < NoneIdx) begin
            // second link write next cycle in S_FLUSH
            prev_d = tail_q; cur_d = slot_q;
          end else begin
            prev_d = NoneIdx;
          end
          pend_d = 1'b1; state_d = S_FLUSH;
          hold_d.status = StOk;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_ALLOC: begin
        if (op_q == OpAlloc) begin
          if (pend_q) begin
            if (alloc_done) begin
              hold_d = '{kind: KindAlloc, status: alloc_ok ? StOk : StNoMem,
                         tag: '0, grp: alloc_grp, found: 1'b0, last: 1'b1};
              state_d = S_OUT;
            end
          end else begin
            alloc_start = 1'b1; pend_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    // add: link old tail to new slot, then send status
    if (state_q == S_FLUSH && op_q == OpAdd) begin
      wr_link = (prev_q != NoneIdx);
      wr_link_idx = prev_q[IW-1:0]; wr_link_val = cur_q;
      hold_d.last = 1'b1; state_d = S_OUT;
    end
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) look_grp = group_id_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; tick_q <= TickReset; used_q <= '0;
      head_q <= NoneIdx; tail_q <= NoneIdx; cur_q <= NoneIdx;
      prev_q <= NoneIdx; slot_q <= '0; pend_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; head_q <= head_d;
      tail_q <= tail_d; cur_q <= cur_d; prev_q <= prev_d; slot_q <= slot_d;
      pend_q <= pend_d; out_v_q <= out_v_d;
      if (cfg_we_i) tick_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d; hold_q <= hold_d;
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) begin
      op_q <= op_i; grp_q <= group_id_i; period_q <= period_i;
      tag_q <= timer_tag_i;
    end
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = out_q.kind;
  assign status_o       = out_q.status;
  assign fired_tag_o    = out_q.tag;
  assign result_group_o = out_q.grp;
  assign found_o        = out_q.found;
  assign last_o         = out_q.last;

  `GOTT_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, state_q != S_IDLE, in_stall_o)
  `GOTT_ASSERT_IMP(a_head_tail, clk_i, rst_ni, used_q == '0, head_q == NoneIdx)
  `GOTT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_v_q && out_stall_i,
                   out_v_q && $stable(out_q))

endmodule
